// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types for the rational arithmetic unit
// Opcodes of an input item and the one-hot sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

	// operation carried by an item
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} opcode_t;

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL1 = 9'b000000010,
		S_MUL2 = 9'b000000100,
		S_MUL3 = 9'b000001000,
		S_MUL4 = 9'b000010000,
		S_GCD  = 9'b000100000,
		S_QNUM = 9'b001000000,
		S_QDEN = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

endpackage

// ===== design/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit: exact fraction arithmetic with gcd reduction
// Forms the cross products of two signed fractions with one shared multiplier
// and reduces them by Euclid's method on one shared restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries opcode, left_num, left_den,
//   right_num and right_den. Output channel out_valid/out_ready carries
//   result_num, result_den and status. An item moves on a cycle with valid
//   and ready both high.
//   The block takes one item at a time: in_ready is high only while the
//   sequencer is idle. States S_MUL1 to S_MUL3 form the products on the single
//   multiplier, then each remainder step of Euclid and each of the two final
//   quotients runs on the restoring divider, one bit per cycle.
//   A flagged item skips the products and the divider and goes straight to
//   the output state.
//   The result sits in an output register, so a stalled receiver does not
//   stop the next item from being accepted and worked on; only the transfer
//   of that next result into the output register waits.
//   Reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module rational_arith_unit import rau_pkg::*; #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic signed [DATA_WIDTH-1:0]  left_num,
	input  logic signed [DATA_WIDTH-1:0]  left_den,
	input  logic signed [DATA_WIDTH-1:0]  right_num,
	input  logic signed [DATA_WIDTH-1:0]  right_den,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [2*DATA_WIDTH:0]  result_num,
	output logic signed [2*DATA_WIDTH-1:0] result_den,
	output logic                          status
);

	localparam int MW = 2 * DATA_WIDTH;
	localparam int CW = $clog2(MW);
	localparam logic [CW-1:0] CNT_LAST = CW'(MW - 1);

	state_t state_q, state_d;

	// operand and product registers
	opcode_t                      op_q;
	logic signed [DATA_WIDTH-1:0] ln_q, ld_q, rn_q, rd_q;
	logic signed [MW-1:0]         prod_q;
	logic signed [MW:0]           num_q;

	// magnitudes and signs of the unreduced fraction
	logic [MW-1:0] nmag_q, dmag_q;
	logic          nneg_q, dneg_q;

	// Euclid operands: a lives in the divider, b is the divisor
	logic          a_neg_q, b_neg_q;
	logic [MW-1:0] b_mag_q;

	// divider state
	logic [MW-1:0] rem_q, quo_q;
	logic [CW-1:0] cnt_q;

	// reduced result and output register
	logic [MW:0]   qn_q;
	logic [MW-1:0] qd_q;
	logic          err_q;
	logic          out_valid_q;
	logic [MW:0]   res_num_q;
	logic [MW-1:0] res_den_q;
	logic          res_err_q;

	logic in_fire, in_err, out_load;

	// shared multiplier
	logic signed [DATA_WIDTH-1:0] mul_a, mul_b;
	logic signed [MW-1:0]         mul_p;

	// shared divider step
	logic [MW:0]   dv_cand;
	logic [MW+1:0] dv_diff;
	logic          dv_fit, dv_last;
	logic [MW-1:0] rem_next, quo_next;

	// magnitudes at the end of the product phase
	logic [MW-1:0] nmag_c, dmag_c;
	logic [MW:0]   num_neg_c, qn_c;
	logic [MW-1:0] den_neg_c, qd_c;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign in_err   = (left_den == '0) || (right_den == '0)
		|| ((opcode_t'(opcode) == OP_DIV) && (right_num == '0));
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// pick multiplier operands for each product step
	always_comb begin
		mul_a = ld_q;
		mul_b = rd_q;
		unique case (state_q)
			S_MUL1: begin
				mul_a = ln_q;
				mul_b = (op_q == OP_MUL) ? rn_q : rd_q;
			end
			S_MUL2: begin
				mul_a = ld_q;
				mul_b = rn_q;
			end
			S_MUL3: begin
				mul_a = ld_q;
				mul_b = (op_q == OP_DIV) ? rn_q : rd_q;
			end
			default: begin
				mul_a = ld_q;
				mul_b = rd_q;
			end
		endcase
	end
	assign mul_p = MW'(mul_a) * MW'(mul_b);

	// one restoring division step on magnitudes
	assign dv_cand  = {rem_q, quo_q[MW-1]};
	assign dv_diff  = {1'b0, dv_cand} - {2'b00, b_mag_q};
	assign dv_fit   = !dv_diff[MW+1];
	assign rem_next = dv_fit ? dv_diff[MW-1:0] : dv_cand[MW-1:0];
	assign quo_next = {quo_q[MW-2:0], dv_fit};
	assign dv_last  = (cnt_q == CNT_LAST);

	// magnitudes of the final numerator and denominator
	assign num_neg_c = -num_q;
	assign den_neg_c = -prod_q;
	assign nmag_c    = num_q[MW] ? num_neg_c[MW-1:0] : num_q[MW-1:0];
	assign dmag_c    = prod_q[MW-1] ? den_neg_c : prod_q;

	// apply the sign of the quotients
	assign qn_c = (nneg_q ^ b_neg_q) ? -{1'b0, quo_next} : {1'b0, quo_next};
	assign qd_c = (dneg_q ^ b_neg_q) ? -quo_next : quo_next;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire)
					state_d = in_err ? S_OUT : S_MUL1;
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_MUL3;
			S_MUL3: state_d = S_MUL4;
			S_MUL4: state_d = S_GCD;
			S_GCD: begin
				if (dv_last && rem_next == '0)
					state_d = S_QNUM;
			end
			S_QNUM: begin
				if (dv_last)
					state_d = S_QDEN;
			end
			S_QDEN: begin
				if (dv_last)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				// capture the item and zero the result, which a flagged item keeps
				if (in_fire) begin
					op_q  <= opcode_t'(opcode);
					ln_q  <= left_num;
					ld_q  <= left_den;
					rn_q  <= right_num;
					rd_q  <= right_den;
					err_q <= in_err;
					qn_q  <= '0;
					qd_q  <= '0;
				end
			end
			S_MUL1: prod_q <= mul_p;
			S_MUL2: begin
				num_q  <= {prod_q[MW-1], prod_q};
				prod_q <= mul_p;
			end
			S_MUL3: begin
				// combine the cross products for add and subtract
				if (op_q == OP_ADD)
					num_q <= num_q + {prod_q[MW-1], prod_q};
				else if (op_q == OP_SUB)
					num_q <= num_q - {prod_q[MW-1], prod_q};
				prod_q <= mul_p;
			end
			S_MUL4: begin
				// split into sign and magnitude, start the first remainder
				nneg_q  <= num_q[MW];
				nmag_q  <= nmag_c;
				dneg_q  <= prod_q[MW-1];
				dmag_q  <= dmag_c;
				a_neg_q <= num_q[MW];
				b_neg_q <= prod_q[MW-1];
				b_mag_q <= dmag_c;
				quo_q   <= nmag_c;
				rem_q   <= '0;
				cnt_q   <= '0;
			end
			S_GCD: begin
				if (!dv_last) begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
				end else if (rem_next == '0) begin
					// b is the gcd: start dividing the numerator by it
					quo_q <= nmag_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					// advance Euclid: a takes b, b takes the signed remainder
					a_neg_q <= b_neg_q;
					b_neg_q <= a_neg_q;
					b_mag_q <= rem_next;
					quo_q   <= b_mag_q;
					rem_q   <= '0;
					cnt_q   <= '0;
				end
			end
			S_QNUM: begin
				if (!dv_last) begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
				end else begin
					qn_q  <= qn_c;
					quo_q <= dmag_q;
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			S_QDEN: begin
				if (!dv_last) begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
				end else begin
					qd_q <= qd_c;
				end
			end
			S_OUT: begin
				// hold until the output register is free
				if (out_load) begin
					res_num_q <= qn_q;
					res_den_q <= qd_q;
					res_err_q <= err_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign result_num = res_num_q;
	assign result_den = res_den_q;
	assign status     = res_err_q;

	// the divisor is never zero while the divider runs
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCD || state_q == S_QNUM || state_q == S_QDEN) |-> b_mag_q != '0)
		else $error("divider running with a zero divisor");

	// the partial remainder stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCD || state_q == S_QNUM || state_q == S_QDEN) |-> rem_q < b_mag_q)
		else $error("partial remainder not below divisor");

	// a flagged item gives a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (result_num == '0 && result_den == '0))
		else $error("flagged item with nonzero result");

	// a good item never gives a zero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status) |-> result_den != '0)
		else $error("zero denominator on a good item");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready straight after an accepted item");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rational arithmetic unit
// Drives fraction pairs with all four opcodes through the valid/ready input,
// predicts each reduced result (cross products, then Euclid with truncating
// remainder) and checks every returned item field by field, in order, while
// both sides idle at random and the receiver once holds off for a long spell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import rau_pkg::*; ();

	localparam int DATA_WIDTH   = 16;
	localparam int RANDOM_ITEMS = 1930;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 4000;
	localparam int DRAIN_CYCLES = 2000;
	localparam int CYCLE_LIMIT  = 16_000_000;

	typedef struct {
		opcode_t                      op;
		logic signed [DATA_WIDTH-1:0] left_num;
		logic signed [DATA_WIDTH-1:0] left_den;
		logic signed [DATA_WIDTH-1:0] right_num;
		logic signed [DATA_WIDTH-1:0] right_den;
	} fraction_pair_t;

	typedef struct {
		logic signed [2*DATA_WIDTH:0]   num;
		logic signed [2*DATA_WIDTH-1:0] den;
		logic                           status;
	} reduced_fraction_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic [1:0]                     opcode    = '0;
	logic signed [DATA_WIDTH-1:0]   left_num  = '0;
	logic signed [DATA_WIDTH-1:0]   left_den  = '0;
	logic signed [DATA_WIDTH-1:0]   right_num = '0;
	logic signed [DATA_WIDTH-1:0]   right_den = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [2*DATA_WIDTH:0]   result_num;
	logic signed [2*DATA_WIDTH-1:0] result_den;
	logic                           status;

	fraction_pair_t    pending_items[$];
	reduced_fraction_t expected_results[$];

	logic in_fired    = 1'b0;
	int   in_gap      = 0;
	int   stall_left  = 0;
	int   hold_left   = 0;
	logic hold_done   = 1'b0;
	int   items_in    = 0;
	int   items_out   = 0;
	int   mismatches  = 0;
	int   flagged     = 0;
	int   negative_den = 0;
	int   op_count[4] = '{0, 0, 0, 0};
	int   cycles      = 0;

	// idle-free stretches recur as the item count advances
	wire calm = (items_in % 400) < 80;

	rational_arith_unit #(.DATA_WIDTH(DATA_WIDTH)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.left_num   (left_num),
		.left_den   (left_den),
		.right_num  (right_num),
		.right_den  (right_den),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_num (result_num),
		.result_den (result_den),
		.status     (status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// cross-multiply, then reduce by Euclid with a remainder that follows the dividend
	function automatic reduced_fraction_t reduced_result(input fraction_pair_t it);
		longint ln, ld, rn, rd, n, d, a, b, r;
		reduced_fraction_t res;
		ln = it.left_num;
		ld = it.left_den;
		rn = it.right_num;
		rd = it.right_den;
		res.num    = '0;
		res.den    = '0;
		res.status = 1'b1;
		if (ld == 0 || rd == 0 || (it.op == OP_DIV && rn == 0))
			return res;
		case (it.op)
			OP_ADD: begin
				n = ln * rd + ld * rn;
				d = ld * rd;
			end
			OP_SUB: begin
				n = ln * rd - ld * rn;
				d = ld * rd;
			end
			OP_MUL: begin
				n = ln * rn;
				d = ld * rd;
			end
			default: begin
				n = ln * rd;
				d = ld * rn;
			end
		endcase
		a = n;
		b = d;
		r = a % b;
		while (r != 0) begin
			a = b;
			b = r;
			r = a % b;
		end
		res.num    = (2*DATA_WIDTH+1)'(n / b);
		res.den    = (2*DATA_WIDTH)'(d / b);
		res.status = 1'b0;
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// full-range, small, extreme and power-of-two-rich values
	function automatic int rand_field();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 40)
			v = $urandom_range(0, 65535) - 32768;
		else if (r < 75)
			v = $urandom_range(0, 48) - 24;
		else if (r < 85) begin
			case ($urandom_range(0, 5))
				0:       v = -32768;
				1:       v = -32767;
				2:       v = -1;
				3:       v = 0;
				4:       v = 1;
				default: v = 32767;
			endcase
		end else begin
			v = $urandom_range(1, 255) << $urandom_range(0, 7);
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v;
	endfunction

	task automatic queue_item(input opcode_t op, input int ln, input int ld,
			input int rn, input int rd);
		fraction_pair_t it;
		it.op        = op;
		it.left_num  = DATA_WIDTH'(ln);
		it.left_den  = DATA_WIDTH'(ld);
		it.right_num = DATA_WIDTH'(rn);
		it.right_den = DATA_WIDTH'(rd);
		pending_items.push_back(it);
	endtask

	// offer queued items, hold each until taken, then idle for a random gap that may be zero
	always @(negedge clk) begin : driver
		fraction_pair_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap   <= 0;
		end else if (!in_valid || in_fired) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (pending_items.size() != 0) begin
				it = pending_items.pop_front();
				opcode    <= it.op;
				left_num  <= it.left_num;
				left_den  <= it.left_den;
				right_num <= it.right_num;
				right_den <= it.right_den;
				in_valid  <= 1'b1;
				in_gap    <= calm ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, once, so the block fills and stalls its input
	always @(negedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_in >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver readiness with random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0)
				stall_left <= pick_gap();
		end
	end

	// record accepted items and check returned results against predictions
	always @(posedge clk) begin : monitor
		fraction_pair_t    it;
		reduced_fraction_t want;
		if (!arst_n) begin
			in_fired = 1'b0;
		end else begin
			in_fired = in_valid && in_ready;
			if (in_valid && in_ready) begin
				it.op        = opcode_t'(opcode);
				it.left_num  = left_num;
				it.left_den  = left_den;
				it.right_num = right_num;
				it.right_den = right_den;
				expected_results.push_back(reduced_result(it));
				op_count[opcode]++;
				items_in++;
			end
			if (out_valid && out_ready) begin
				items_out++;
				if (status)
					flagged++;
				if (result_den < 0)
					negative_den++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result %0d/%0d status %0b", $realtime,
							result_num, result_den, status);
				end else begin
					want = expected_results.pop_front();
					if (result_num !== want.num || result_den !== want.den ||
							status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result %0d expected %0d/%0d st %0b, got %0d/%0d st %0b",
								$realtime, items_out, want.num, want.den, want.status,
								result_num, result_den, status);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding", cycles,
				expected_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int n;
		int ld;
		int rd;
		// plain cases of each operation
		queue_item(OP_ADD, 1, 2, 1, 3);
		queue_item(OP_SUB, 1, 2, 1, 3);
		queue_item(OP_MUL, 2, 3, 3, 4);
		queue_item(OP_DIV, 2, 3, 4, 5);
		// gcd comes out negative, so the denominator does too
		queue_item(OP_ADD, -1, 2, 0, 1);
		// zero numerator reduces to 0/1
		queue_item(OP_MUL, 0, 5, 7, 3);
		queue_item(OP_SUB, 3, 4, 3, 4);
		queue_item(OP_DIV, 0, 5, 3, 7);
		// zero denominators and division by a zero fraction
		queue_item(OP_ADD, 1, 0, 1, 1);
		queue_item(OP_MUL, 1, 1, 1, 0);
		queue_item(OP_DIV, 1, 1, 0, 7);
		queue_item(OP_DIV, 0, 0, 0, 0);
		queue_item(OP_SUB, 5, 0, 3, 0);
		// field extremes
		queue_item(OP_ADD, -32768, -32768, -32768, -32768);
		queue_item(OP_SUB, 32767, -32768, -32768, 32767);
		queue_item(OP_MUL, -32768, 1, -32768, 1);
		queue_item(OP_DIV, 32767, -32768, -32768, 32767);
		queue_item(OP_MUL, -1, -1, -1, -1);
		queue_item(OP_ADD, 32767, 32767, 32767, 1);
		queue_item(OP_SUB, -32768, 32767, 32767, -32768);
		queue_item(OP_DIV, -32768, 32767, 32767, -32768);
		queue_item(OP_MUL, 32767, -1, 32767, -1);
		queue_item(OP_ADD, 1, -1, -1, 1);

		// random items, nearly all with usable denominators
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			ld = rand_field();
			rd = rand_field();
			if (ld == 0 && $urandom_range(0, 9) != 0)
				ld = $urandom_range(1, 9);
			if (rd == 0 && $urandom_range(0, 9) != 0)
				rd = $urandom_range(1, 9);
			queue_item(opcode_t'($urandom_range(0, 3)), rand_field(), ld, rand_field(), rd);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for every item to go in and every result to come back
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d items (%0d add, %0d sub, %0d mul, %0d div), %0d results back",
			items_in, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
			op_count[OP_DIV], items_out);
		$display("Of those %0d were flagged and %0d carried a negative denominator",
			flagged, negative_den);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
